// ----- hw/rtl/assert_macros.svh -----
// Assertion macros used by the top RTL file of the car-following block.
// No dependencies; the macros expand to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`define ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("invariant check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_ALWAYS(label, clk, rst, cond)
`endif
`endif

// ----- hw/rtl/idm_pkg.sv -----
// Types and constants of the IDM car-following block.
// No dependencies.
package idm_pkg;

   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned OP_W = 4;
   localparam int unsigned DIV_STEPS = 48;

   localparam logic [31:0] QONE = 32'h0001_0000;
   localparam logic [31:0] USAT = 32'hFFFF_FFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ACCEL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DECEL = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DESIRED_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_GAP = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_TIME = 3'd4;

   localparam logic [30:0] RST_MAX_ACCEL = 31'd65536;
   localparam logic [31:0] RST_MAX_DECEL = 32'hFFFD_0000;
   localparam logic [30:0] RST_DESIRED_SPEED = 31'd1966080;
   localparam logic [30:0] RST_MIN_GAP = 31'd131072;
   localparam logic [30:0] RST_STEP_TIME = 31'd6554;

   // datapath operations
   localparam logic [OP_W-1:0] OP_DIV_V = 4'd0;
   localparam logic [OP_W-1:0] OP_POW = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL_ROOT = 4'd2;
   localparam logic [OP_W-1:0] OP_SQ_ROOT = 4'd3;
   localparam logic [OP_W-1:0] OP_MUL_SS = 4'd4;
   localparam logic [OP_W-1:0] OP_DIV_SS = 4'd5;
   localparam logic [OP_W-1:0] OP_MUL_AX = 4'd6;
   localparam logic [OP_W-1:0] OP_MUL_AY = 4'd7;
   localparam logic [OP_W-1:0] OP_SQ_GAP = 4'd8;
   localparam logic [OP_W-1:0] OP_DIV_G = 4'd9;
   localparam logic [OP_W-1:0] OP_MUL_GSQ = 4'd10;
   localparam logic [OP_W-1:0] OP_MUL_ACC = 4'd11;
   localparam logic [OP_W-1:0] OP_MUL_VEL = 4'd12;
   localparam logic [OP_W-1:0] OP_MUL_DIST = 4'd13;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic go;
      logic wb;
      logic load_in;
      logic load_out;
   } idm_cmd_type;

   typedef struct packed {
      logic div_done;
      logic sqrt_done;
      logic lead;
   } idm_status_type;

endpackage

// ----- hw/rtl/idm_channels.sv -----
// Handshake channel interfaces of the IDM car-following block.
// Depends on idm_pkg for the register index width.
interface idm_req_if;
   logic valid;
   logic ready;
   logic signed [31:0] own_x;
   logic signed [31:0] own_y;
   logic leader_present;
   logic signed [31:0] leader_x;
   logic signed [31:0] leader_y;
   modport source (output valid, own_x, own_y, leader_present, leader_x, leader_y,
                   input ready);
   modport sink (input valid, own_x, own_y, leader_present, leader_x, leader_y,
                 output ready);
endinterface

interface idm_rsp_if;
   logic valid;
   logic ready;
   logic signed [31:0] accel_out;
   logic [30:0] speed_out;
   logic signed [31:0] distance_out;
   modport source (output valid, accel_out, speed_out, distance_out, input ready);
   modport sink (input valid, accel_out, speed_out, distance_out, output ready);
endinterface

interface idm_csr_if;
   logic valid;
   logic ready;
   logic [idm_pkg::CSR_IDX_W-1:0] index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/idm_div.sv -----
// Restoring divider: (num << 16) / den, one quotient bit per cycle.
// Depends on idm_pkg; saturates to all ones on a zero divisor or overflow.
module idm_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [31:0] quot
);
   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [47:0] dq_ff;
   logic [31:0] rem_ff;
   logic [31:0] den_ff;
   logic        zero_ff;
   logic [32:0] shifted;
   logic [32:0] diff;
   logic        ge;

   always_comb begin
      shifted = {rem_ff, dq_ff[47]};
      diff = shifted - {1'b0, den_ff};
      ge = shifted >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == 6'(idm_pkg::DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff <= {num, 16'h0000};
         rem_ff <= '0;
         den_ff <= den;
         zero_ff <= (den == 32'h0);
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[31:0] : shifted[31:0];
         dq_ff <= {dq_ff[46:0], ge};
      end
   end

   assign done = done_ff;
   assign quot = (zero_ff || (|dq_ff[47:32])) ? idm_pkg::USAT : dq_ff[31:0];
endmodule

// ----- hw/rtl/idm_sqrt.sv -----
// Floor square root of a 64-bit value, one result bit per cycle.
// Depends on nothing but its ports.
module idm_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] x_in,
   output logic        done,
   output logic [31:0] root
);
   logic        busy_ff;
   logic        done_ff;
   logic [63:0] x_ff;
   logic [63:0] res_ff;
   logic [63:0] bit_ff;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && bit_ff[0]) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff <= x_in;
         res_ff <= '0;
         bit_ff <= 64'h4000_0000_0000_0000;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_ff <= x_ff - trial;
            res_ff <= (res_ff >> 1) + bit_ff;
         end else begin
            res_ff <= res_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign done = done_ff;
   assign root = res_ff[31:0];
endmodule

// ----- hw/rtl/idm_dp.sv -----
// Datapath: registers, shared multiplier, divider and square root units.
// Depends on idm_pkg, idm_div and idm_sqrt.
module idm_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  idm_pkg::idm_cmd_type          cmd,
   output idm_pkg::idm_status_type       status,
   input  logic signed [31:0]            own_x,
   input  logic signed [31:0]            own_y,
   input  logic                          leader_present,
   input  logic signed [31:0]            leader_x,
   input  logic signed [31:0]            leader_y,
   input  logic                          csr_write,
   input  logic [idm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                   csr_data,
   output logic signed [31:0]            accel_out,
   output logic [30:0]                   speed_out,
   output logic signed [31:0]            distance_out
);
   localparam logic signed [49:0] S32_MAX = 50'sh0_7FFF_FFFF;
   localparam logic signed [49:0] S32_MIN = -50'sh0_8000_0000;

   logic [30:0] max_accel_ff, desired_ff, min_gap_ff, step_ff;
   logic [31:0] max_decel_ff;
   logic [30:0] speed_ff;
   logic [31:0] dist_ff;
   logic        lead_ff;
   logic [31:0] ax_ff, ay_ff, qv_ff, term_ff, root_ff, sstar_ff, gap_ff, qg_ff, acc_ff;
   logic [63:0] sx_ff, sum_ff, prod_ff;
   logic        ovf_ff;
   logic [31:0] accel_o_ff, dist_o_ff;
   logic [30:0] speed_o_ff;

   logic        is_mul, is_div, is_sqrt, wb_en;
   logic [31:0] mul_a, mul_b, div_num, div_den, div_q, sq_root, nd, acc_abs;
   logic [63:0] sq_in;
   logic        div_done, sqrt_done;
   logic [32:0] dx, dy, tdiff;
   logic        term_neg;
   logic [31:0] term_mag, p_sat;
   logic [47:0] p_hi;
   logic signed [49:0] p_s, acc_raw, acc_c1, acc_c2, vn, dn, maxa, mind;
   logic [31:0] acc_sat;
   logic [30:0] vn_sat;
   logic [31:0] dn_sat;
   logic [64:0] sum_w;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? idm_pkg::USAT : s[31:0];
   endfunction

   always_comb begin
      is_mul = 1'b0;
      is_div = 1'b0;
      is_sqrt = 1'b0;
      case (cmd.op)
         idm_pkg::OP_DIV_V, idm_pkg::OP_DIV_SS, idm_pkg::OP_DIV_G: is_div = 1'b1;
         idm_pkg::OP_SQ_ROOT, idm_pkg::OP_SQ_GAP: is_sqrt = 1'b1;
         default: is_mul = 1'b1;
      endcase
   end

   assign wb_en = cmd.wb && (is_div ? div_done : (is_sqrt ? sqrt_done : 1'b1));

   // negated deceleration, positive settings count as zero
   assign nd = max_decel_ff[31] ? (~max_decel_ff + 32'd1) : 32'd0;
   assign acc_abs = acc_ff[31] ? (~acc_ff + 32'd1) : acc_ff;
   assign tdiff = {1'b0, idm_pkg::QONE} - {1'b0, term_ff};
   assign term_neg = tdiff[32];
   assign term_mag = term_neg ? (~tdiff[31:0] + 32'd1) : tdiff[31:0];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         idm_pkg::OP_POW: begin
            mul_a = term_ff;
            mul_b = qv_ff;
         end
         idm_pkg::OP_MUL_ROOT: begin
            mul_a = nd;
            mul_b = {1'b0, max_accel_ff};
         end
         idm_pkg::OP_MUL_SS, idm_pkg::OP_MUL_DIST: begin
            mul_a = {1'b0, speed_ff};
            mul_b = {1'b0, step_ff};
         end
         idm_pkg::OP_MUL_AX: begin
            mul_a = ax_ff;
            mul_b = ax_ff;
         end
         idm_pkg::OP_MUL_AY: begin
            mul_a = ay_ff;
            mul_b = ay_ff;
         end
         idm_pkg::OP_MUL_GSQ: begin
            mul_a = qg_ff;
            mul_b = qg_ff;
         end
         idm_pkg::OP_MUL_ACC: begin
            mul_a = term_mag;
            mul_b = {1'b0, max_accel_ff};
         end
         idm_pkg::OP_MUL_VEL: begin
            mul_a = acc_abs;
            mul_b = {1'b0, step_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      div_num = {1'b0, speed_ff};
      div_den = {1'b0, desired_ff};
      sq_in = prod_ff;
      case (cmd.op)
         idm_pkg::OP_DIV_SS: div_den = {root_ff[30:0], 1'b0};
         idm_pkg::OP_DIV_G: begin
            div_num = sstar_ff;
            div_den = gap_ff;
         end
         idm_pkg::OP_SQ_GAP: sq_in = sum_ff;
         default: div_den = {1'b0, desired_ff};
      endcase
   end

   idm_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.go && is_div),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   idm_sqrt u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.go && is_sqrt),
      .x_in  (sq_in),
      .done  (sqrt_done),
      .root  (sq_root)
   );

   // product post-processing, the sum of squares and the position differences
   always_comb begin
      p_hi = prod_ff[63:16];
      p_sat = (|prod_ff[63:48]) ? idm_pkg::USAT : prod_ff[47:16];
      p_s = $signed({2'b00, p_hi});
      maxa = $signed({19'h0, max_accel_ff});
      mind = $signed({{18{max_decel_ff[31]}}, max_decel_ff});

      acc_raw = term_neg ? -p_s : p_s;
      acc_c1 = (lead_ff && (acc_raw > maxa)) ? maxa : acc_raw;
      acc_c2 = (lead_ff && (acc_c1 < mind)) ? mind : acc_c1;
      if (acc_c2 > S32_MAX) begin
         acc_sat = 32'h7FFF_FFFF;
      end else if (acc_c2 < S32_MIN) begin
         acc_sat = 32'h8000_0000;
      end else begin
         acc_sat = acc_c2[31:0];
      end

      vn = $signed({19'h0, speed_ff}) + (acc_ff[31] ? -p_s : p_s);
      if (vn < 50'sd0) begin
         vn_sat = '0;
      end else if (vn > S32_MAX) begin
         vn_sat = 31'h7FFF_FFFF;
      end else begin
         vn_sat = vn[30:0];
      end

      dn = $signed({{18{dist_ff[31]}}, dist_ff}) + p_s;
      dn_sat = (dn > S32_MAX) ? 32'h7FFF_FFFF : dn[31:0];

      sum_w = {1'b0, sx_ff} + {1'b0, prod_ff};
      dx = {own_x[31], own_x} - {leader_x[31], leader_x};
      dy = {own_y[31], own_y} - {leader_y[31], leader_y};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_accel_ff <= idm_pkg::RST_MAX_ACCEL;
         max_decel_ff <= idm_pkg::RST_MAX_DECEL;
         desired_ff <= idm_pkg::RST_DESIRED_SPEED;
         min_gap_ff <= idm_pkg::RST_MIN_GAP;
         step_ff <= idm_pkg::RST_STEP_TIME;
      end else if (csr_write) begin
         case (csr_index)
            idm_pkg::CSR_MAX_ACCEL: max_accel_ff <= csr_data[30:0];
            idm_pkg::CSR_MAX_DECEL: max_decel_ff <= csr_data;
            idm_pkg::CSR_DESIRED_SPEED: desired_ff <= csr_data[30:0];
            idm_pkg::CSR_MIN_GAP: min_gap_ff <= csr_data[30:0];
            idm_pkg::CSR_STEP_TIME: step_ff <= csr_data[30:0];
            default: max_accel_ff <= max_accel_ff;
         endcase
      end
   end

   // vehicle state
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= '0;
         dist_ff <= '0;
         lead_ff <= 1'b0;
      end else begin
         if (cmd.load_in) begin
            lead_ff <= leader_present;
         end
         if (wb_en && (cmd.op == idm_pkg::OP_MUL_VEL)) begin
            speed_ff <= vn_sat;
         end
         if (wb_en && (cmd.op == idm_pkg::OP_MUL_DIST)) begin
            dist_ff <= dn_sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         ax_ff <= dx[32] ? (~dx[31:0] + 32'd1) : dx[31:0];
         ay_ff <= dy[32] ? (~dy[31:0] + 32'd1) : dy[31:0];
      end
      if (cmd.go && is_mul) begin
         prod_ff <= {32'h0, mul_a} * {32'h0, mul_b};
      end
      if (wb_en) begin
         case (cmd.op)
            idm_pkg::OP_DIV_V: begin
               qv_ff <= div_q;
               term_ff <= div_q;
            end
            idm_pkg::OP_POW: term_ff <= p_sat;
            idm_pkg::OP_SQ_ROOT: root_ff <= sq_root;
            idm_pkg::OP_MUL_SS: sstar_ff <= sat_add(p_sat, {1'b0, min_gap_ff});
            idm_pkg::OP_DIV_SS: sstar_ff <= sat_add(sstar_ff, div_q);
            idm_pkg::OP_MUL_AX: sx_ff <= prod_ff;
            idm_pkg::OP_MUL_AY: begin
               ovf_ff <= sum_w[64];
               sum_ff <= sum_w[63:0];
            end
            idm_pkg::OP_SQ_GAP: gap_ff <= ovf_ff ? idm_pkg::USAT : sq_root;
            idm_pkg::OP_DIV_G: qg_ff <= div_q;
            idm_pkg::OP_MUL_GSQ: term_ff <= sat_add(term_ff, p_sat);
            idm_pkg::OP_MUL_ACC: acc_ff <= acc_sat;
            default: qg_ff <= qg_ff;
         endcase
      end
      if (cmd.load_out) begin
         accel_o_ff <= acc_ff;
         speed_o_ff <= speed_ff;
         dist_o_ff <= dist_ff;
      end
   end

   assign status.div_done = div_done;
   assign status.sqrt_done = sqrt_done;
   assign status.lead = lead_ff;
   assign accel_out = accel_o_ff;
   assign speed_out = speed_o_ff;
   assign distance_out = dist_o_ff;
endmodule

// ----- hw/rtl/idm_ctrl.sv -----
// Controller: sequences one request through the datapath and owns the
// request and response handshakes. Depends on idm_pkg.
module idm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   input  idm_pkg::idm_status_type status,
   output idm_pkg::idm_cmd_type    cmd
);
   localparam logic [4:0] ST_IDLE = 5'd0;
   localparam logic [4:0] ST_DIVV_GO = 5'd1;
   localparam logic [4:0] ST_DIVV_WAIT = 5'd2;
   localparam logic [4:0] ST_POW_M = 5'd3;
   localparam logic [4:0] ST_POW_W = 5'd4;
   localparam logic [4:0] ST_ROOT_M = 5'd5;
   localparam logic [4:0] ST_ROOT_GO = 5'd6;
   localparam logic [4:0] ST_ROOT_WAIT = 5'd7;
   localparam logic [4:0] ST_SS_M = 5'd8;
   localparam logic [4:0] ST_SS_W = 5'd9;
   localparam logic [4:0] ST_DIVSS_GO = 5'd10;
   localparam logic [4:0] ST_DIVSS_WAIT = 5'd11;
   localparam logic [4:0] ST_AX_M = 5'd12;
   localparam logic [4:0] ST_AX_W = 5'd13;
   localparam logic [4:0] ST_AY_M = 5'd14;
   localparam logic [4:0] ST_AY_W = 5'd15;
   localparam logic [4:0] ST_GAP_GO = 5'd16;
   localparam logic [4:0] ST_GAP_WAIT = 5'd17;
   localparam logic [4:0] ST_DIVG_GO = 5'd18;
   localparam logic [4:0] ST_DIVG_WAIT = 5'd19;
   localparam logic [4:0] ST_GSQ_M = 5'd20;
   localparam logic [4:0] ST_GSQ_W = 5'd21;
   localparam logic [4:0] ST_ACC_M = 5'd22;
   localparam logic [4:0] ST_ACC_W = 5'd23;
   localparam logic [4:0] ST_VEL_M = 5'd24;
   localparam logic [4:0] ST_VEL_W = 5'd25;
   localparam logic [4:0] ST_DIST_M = 5'd26;
   localparam logic [4:0] ST_DIST_W = 5'd27;
   localparam logic [4:0] ST_OUT = 5'd28;

   logic [4:0] state_ff, state_in;
   logic [1:0] pow_cnt_ff, pow_cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      pow_cnt_in = pow_cnt_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               state_in = ST_DIVV_GO;
            end
         end
         ST_DIVV_GO: begin
            cmd.op = idm_pkg::OP_DIV_V;
            cmd.go = 1'b1;
            pow_cnt_in = '0;
            state_in = ST_DIVV_WAIT;
         end
         ST_DIVV_WAIT: begin
            cmd.op = idm_pkg::OP_DIV_V;
            cmd.wb = 1'b1;
            if (status.div_done) state_in = ST_POW_M;
         end
         ST_POW_M: begin
            cmd.op = idm_pkg::OP_POW;
            cmd.go = 1'b1;
            state_in = ST_POW_W;
         end
         ST_POW_W: begin
            cmd.op = idm_pkg::OP_POW;
            cmd.wb = 1'b1;
            pow_cnt_in = pow_cnt_ff + 2'd1;
            // three products give the fourth power
            if (pow_cnt_ff == 2'd2) begin
               state_in = status.lead ? ST_ROOT_M : ST_ACC_M;
            end else begin
               state_in = ST_POW_M;
            end
         end
         ST_ROOT_M: begin
            cmd.op = idm_pkg::OP_MUL_ROOT;
            cmd.go = 1'b1;
            state_in = ST_ROOT_GO;
         end
         ST_ROOT_GO: begin
            cmd.op = idm_pkg::OP_SQ_ROOT;
            cmd.go = 1'b1;
            state_in = ST_ROOT_WAIT;
         end
         ST_ROOT_WAIT: begin
            cmd.op = idm_pkg::OP_SQ_ROOT;
            cmd.wb = 1'b1;
            if (status.sqrt_done) state_in = ST_SS_M;
         end
         ST_SS_M: begin
            cmd.op = idm_pkg::OP_MUL_SS;
            cmd.go = 1'b1;
            state_in = ST_SS_W;
         end
         ST_SS_W: begin
            cmd.op = idm_pkg::OP_MUL_SS;
            cmd.wb = 1'b1;
            state_in = ST_DIVSS_GO;
         end
         ST_DIVSS_GO: begin
            cmd.op = idm_pkg::OP_DIV_SS;
            cmd.go = 1'b1;
            state_in = ST_DIVSS_WAIT;
         end
         ST_DIVSS_WAIT: begin
            cmd.op = idm_pkg::OP_DIV_SS;
            cmd.wb = 1'b1;
            if (status.div_done) state_in = ST_AX_M;
         end
         ST_AX_M: begin
            cmd.op = idm_pkg::OP_MUL_AX;
            cmd.go = 1'b1;
            state_in = ST_AX_W;
         end
         ST_AX_W: begin
            cmd.op = idm_pkg::OP_MUL_AX;
            cmd.wb = 1'b1;
            state_in = ST_AY_M;
         end
         ST_AY_M: begin
            cmd.op = idm_pkg::OP_MUL_AY;
            cmd.go = 1'b1;
            state_in = ST_AY_W;
         end
         ST_AY_W: begin
            cmd.op = idm_pkg::OP_MUL_AY;
            cmd.wb = 1'b1;
            state_in = ST_GAP_GO;
         end
         ST_GAP_GO: begin
            cmd.op = idm_pkg::OP_SQ_GAP;
            cmd.go = 1'b1;
            state_in = ST_GAP_WAIT;
         end
         ST_GAP_WAIT: begin
            cmd.op = idm_pkg::OP_SQ_GAP;
            cmd.wb = 1'b1;
            if (status.sqrt_done) state_in = ST_DIVG_GO;
         end
         ST_DIVG_GO: begin
            cmd.op = idm_pkg::OP_DIV_G;
            cmd.go = 1'b1;
            state_in = ST_DIVG_WAIT;
         end
         ST_DIVG_WAIT: begin
            cmd.op = idm_pkg::OP_DIV_G;
            cmd.wb = 1'b1;
            if (status.div_done) state_in = ST_GSQ_M;
         end
         ST_GSQ_M: begin
            cmd.op = idm_pkg::OP_MUL_GSQ;
            cmd.go = 1'b1;
            state_in = ST_GSQ_W;
         end
         ST_GSQ_W: begin
            cmd.op = idm_pkg::OP_MUL_GSQ;
            cmd.wb = 1'b1;
            state_in = ST_ACC_M;
         end
         ST_ACC_M: begin
            cmd.op = idm_pkg::OP_MUL_ACC;
            cmd.go = 1'b1;
            state_in = ST_ACC_W;
         end
         ST_ACC_W: begin
            cmd.op = idm_pkg::OP_MUL_ACC;
            cmd.wb = 1'b1;
            state_in = ST_VEL_M;
         end
         ST_VEL_M: begin
            cmd.op = idm_pkg::OP_MUL_VEL;
            cmd.go = 1'b1;
            state_in = ST_VEL_W;
         end
         ST_VEL_W: begin
            cmd.op = idm_pkg::OP_MUL_VEL;
            cmd.wb = 1'b1;
            state_in = ST_DIST_M;
         end
         ST_DIST_M: begin
            cmd.op = idm_pkg::OP_MUL_DIST;
            cmd.go = 1'b1;
            state_in = ST_DIST_W;
         end
         ST_DIST_W: begin
            cmd.op = idm_pkg::OP_MUL_DIST;
            cmd.wb = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // hold until the output register is free
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pow_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pow_cnt_ff <= pow_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

// ----- hw/rtl/idm_car_following_step.sv -----
// Intelligent Driver Model car-following step, Q16.16 fixed point.
// Requests on req_ch carry the vehicle position and an optional leader
// position; each request yields one response on rsp_ch with the
// acceleration, the updated speed and the updated traveled distance.
// Five registers (max_accel, max_decel, desired_speed, min_gap, step_time)
// are written through csr_ch, indexes 0 to 4; csr_ch is always ready and
// must only be written while no request is in flight.
// One request is worked on at a time; without a leader it takes one pass
// through the shared 48-step divider, with a leader three divisions and
// two passes through the 32-step square root unit. req_ch is ready again
// once the result sits in the output register, so the next request
// starts while the previous response waits; if rsp_ch stalls, the next
// result holds in the datapath while the controller waits until the
// output register is taken.
// Reset (synchronous, active high) clears speed and distance to zero and
// loads the register defaults; no response is pending after reset.
// Depends on idm_pkg, idm_channels, idm_ctrl, idm_dp, assert_macros.svh.
`include "assert_macros.svh"
module idm_car_following_step (
   input logic        clock,
   input logic        reset,
   idm_req_if.sink    req_ch,
   idm_rsp_if.source  rsp_ch,
   idm_csr_if.sink    csr_ch
);
   idm_pkg::idm_cmd_type    cmd;
   idm_pkg::idm_status_type status;

   assign csr_ch.ready = 1'b1;

   idm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .status    (status),
      .cmd       (cmd)
   );

   idm_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .own_x          (req_ch.own_x),
      .own_y          (req_ch.own_y),
      .leader_present (req_ch.leader_present),
      .leader_x       (req_ch.leader_x),
      .leader_y       (req_ch.leader_y),
      .csr_write      (csr_ch.valid),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .accel_out      (rsp_ch.accel_out),
      .speed_out      (rsp_ch.speed_out),
      .distance_out   (rsp_ch.distance_out)
   );

   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.load_out, !rsp_ch.valid || rsp_ch.ready)
   `ASSERT_NEXT(a_busy_after_accept, clock, reset, req_ch.valid && req_ch.ready, !req_ch.ready)
   `ASSERT_ALWAYS(a_one_unit_done, clock, reset, $onehot0({status.div_done, status.sqrt_done}))
endmodule
